[src/tccw_pkg.sv]
// Shared constants, payload types and controller command codes of the text console writer.
package tccw_pkg;

   localparam int COLUMNS       = 80;
   localparam int SCROLL_ROW    = 24;
   localparam int CELL_COUNT    = COLUMNS * (SCROLL_ROW + 1);
   localparam int COPY_COUNT    = (SCROLL_ROW - 1) * COLUMNS;
   localparam int LAST_ROW_BASE = (SCROLL_ROW - 1) * COLUMNS;
   localparam int SCROLL_BASE   = SCROLL_ROW * COLUMNS;

   localparam int CELL_W   = $clog2(CELL_COUNT);
   localparam int COL_W    = $clog2(COLUMNS);
   localparam int ROW_W    = $clog2(SCROLL_ROW + 1);
   localparam int DATA_W   = 16;
   localparam int ATTR_W   = 8;
   localparam int CHAR_W   = 9;
   localparam int INDEX_W  = 11;
   localparam int CURSOR_W = 11;

   localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h07;
   localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 9'd10;
   localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 9'h100;
   localparam logic [7:0]        BLANK_CHAR     = 8'h20;

   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic                command;
      logic [CHAR_W-1:0]   char_code;
      logic [INDEX_W-1:0]  cell_index;
   } req_type;

   typedef struct packed {
      logic [CURSOR_W-1:0] cursor_pos;
      logic [DATA_W-1:0]   read_data;
      logic                scrolled;
   } rsp_type;

   typedef enum logic [2:0] {
      DP_IDLE,
      DP_LOAD,
      DP_EXEC,
      DP_CLEAR_ALL,
      DP_COPY,
      DP_CLEAR_ROW,
      DP_BLANK,
      DP_READ_RESP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_read;
      logic need_scroll;
      logic all_last;
      logic copy_last;
      logic row_last;
   } dp_status_type;

endpackage

[src/tccw_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/tccw_ctrl.sv]
// Controller state machine sequencing puts, reads, scroll copies and clearing sweeps.
module tccw_ctrl
   import tccw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_valid,
   output ctrl_cmd_type  cmd,
   input  dp_status_type status
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_RDATA,
      ST_COPY,
      ST_CLR_ROW,
      ST_BLANK
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd.op       = DP_IDLE;
      case (state_ff)
         ST_CLEAR: begin
            cmd.op = DP_CLEAR_ALL;
            if (status.all_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.op   = DP_LOAD;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.op = DP_EXEC;
            if (status.is_read) begin
               state_in = ST_RDATA;
            end else if (status.need_scroll) begin
               state_in = ST_COPY;
            end else begin
               state_in = ST_BLANK;
            end
         end
         ST_RDATA: begin
            cmd.op       = DP_READ_RESP;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_COPY: begin
            cmd.op = DP_COPY;
            if (status.copy_last) begin
               state_in = ST_CLR_ROW;
            end
         end
         ST_CLR_ROW: begin
            cmd.op = DP_CLEAR_ROW;
            if (status.row_last) begin
               state_in = ST_BLANK;
            end
         end
         ST_BLANK: begin
            cmd.op       = DP_BLANK;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[src/tccw_dpath.sv]
// Datapath: cursor, attribute register, sweep counter, screen store and result register.
module tccw_dpath
   import tccw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd,
   output dp_status_type     status,
   input  req_type           req_payload,
   output rsp_type           rsp_payload,
   input  logic              csr_wr,
   input  logic [ATTR_W-1:0] csr_wdata
);

   req_type             req_ff;
   rsp_type             rsp_ff, rsp_in;
   logic [CELL_W-1:0]   cursor_ff, cursor_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [ATTR_W-1:0]   attr_ff;
   logic [CELL_W-1:0]   cnt_ff, cnt_in;
   logic                pend_ff;
   logic [CELL_W-1:0]   pend_addr_ff;
   logic                in_range_ff;
   logic                scrolled_ff;

   logic [CELL_W-1:0]   pos_n;
   logic [COL_W-1:0]    col_n;
   logic [ROW_W-1:0]    row_n;
   logic                need_scroll;
   logic                char_write;
   logic                in_range;

   logic                wr_en, rd_en;
   logic [CELL_W-1:0]   wr_addr, rd_addr;
   logic [DATA_W-1:0]   wr_data, rd_data;

   // next cursor for a put
   always_comb begin
      pos_n      = cursor_ff;
      col_n      = col_ff;
      row_n      = row_ff;
      char_write = 1'b0;
      if (req_ff.char_code == CODE_NEWLINE) begin
         pos_n = cursor_ff - CELL_W'(col_ff) + CELL_W'(COLUMNS);
         col_n = '0;
         row_n = row_ff + 1'b1;
      end else if (req_ff.char_code == CODE_BACKSPACE) begin
         if (cursor_ff != '0) begin
            pos_n = cursor_ff - 1'b1;
            if (col_ff == '0) begin
               col_n = COL_W'(COLUMNS - 1);
               row_n = row_ff - 1'b1;
            end else begin
               col_n = col_ff - 1'b1;
            end
         end
      end else begin
         char_write = 1'b1;
         pos_n      = cursor_ff + 1'b1;
         if (col_ff == COL_W'(COLUMNS - 1)) begin
            col_n = '0;
            row_n = row_ff + 1'b1;
         end else begin
            col_n = col_ff + 1'b1;
         end
      end
      need_scroll = (row_n == ROW_W'(SCROLL_ROW));
   end

   assign in_range = (32'(req_ff.cell_index) < CELL_COUNT);

   // store port selection
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff;
      wr_data = '0;
      rd_en   = 1'b0;
      rd_addr = CELL_W'(req_ff.cell_index);
      case (cmd.op)
         DP_EXEC: begin
            if (req_ff.command == CMD_READ) begin
               rd_en = 1'b1;
            end else if (char_write) begin
               wr_en   = 1'b1;
               wr_addr = cursor_ff;
               wr_data = {attr_ff, req_ff.char_code[7:0]};
            end
         end
         DP_CLEAR_ALL, DP_CLEAR_ROW: begin
            wr_en = 1'b1;
         end
         DP_COPY: begin
            wr_en   = pend_ff;
            wr_addr = pend_addr_ff;
            wr_data = rd_data;
            rd_en   = (cnt_ff != CELL_W'(COPY_COUNT));
            rd_addr = CELL_W'(cnt_ff + CELL_W'(COLUMNS));
         end
         DP_BLANK: begin
            wr_en   = 1'b1;
            wr_addr = cursor_ff;
            wr_data = {attr_ff, BLANK_CHAR};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      cursor_in = cursor_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      cnt_in    = cnt_ff;
      rsp_in    = rsp_ff;
      case (cmd.op)
         DP_EXEC: begin
            cnt_in = '0;
            if (req_ff.command == CMD_PUT) begin
               col_in = col_n;
               if (need_scroll) begin
                  cursor_in = pos_n - CELL_W'(COLUMNS);
                  row_in    = ROW_W'(SCROLL_ROW - 1);
               end else begin
                  cursor_in = pos_n;
                  row_in    = row_n;
               end
            end
         end
         DP_CLEAR_ALL, DP_CLEAR_ROW: begin
            cnt_in = cnt_ff + 1'b1;
         end
         DP_COPY: begin
            if (cnt_ff == CELL_W'(COPY_COUNT)) begin
               cnt_in = CELL_W'(LAST_ROW_BASE);
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         DP_BLANK: begin
            rsp_in.cursor_pos = CURSOR_W'(cursor_ff);
            rsp_in.read_data  = '0;
            rsp_in.scrolled   = scrolled_ff;
         end
         DP_READ_RESP: begin
            rsp_in.cursor_pos = CURSOR_W'(cursor_ff);
            rsp_in.read_data  = in_range_ff ? rd_data : '0;
            rsp_in.scrolled   = 1'b0;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         cnt_ff    <= '0;
         pend_ff   <= 1'b0;
         attr_ff   <= ATTR_RESET;
      end else begin
         cursor_ff <= cursor_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         cnt_ff    <= cnt_in;
         pend_ff   <= (cmd.op == DP_COPY) && (cnt_ff != CELL_W'(COPY_COUNT));
         if (csr_wr) begin
            attr_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= cnt_ff;
      rsp_ff       <= rsp_in;
      if (cmd.op == DP_LOAD) begin
         req_ff <= req_payload;
      end
      if (cmd.op == DP_EXEC) begin
         in_range_ff <= in_range;
         scrolled_ff <= need_scroll && (req_ff.command == CMD_PUT);
      end
   end

   tccw_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign status.is_read     = (req_ff.command == CMD_READ);
   assign status.need_scroll = need_scroll;
   assign status.all_last    = (cnt_ff == CELL_W'(CELL_COUNT - 1));
   assign status.copy_last   = (cnt_ff == CELL_W'(COPY_COUNT));
   assign status.row_last    = (cnt_ff == CELL_W'(SCROLL_BASE - 1));
   assign rsp_payload        = rsp_ff;

endmodule

[src/text_console_character_writer.sv]
// Top level of the text console character writer: controller plus datapath.
//
// Use:
//   Request channel: drive req_payload and raise start; the item is taken at
//   a rising edge where start is high and busy is low. A put (command 0)
//   writes, backspaces or starts a new line and then blanks the cursor cell;
//   a read (command 1) returns one screen cell and changes nothing.
//   Result channel: rsp_valid is high for exactly one cycle with rsp_payload;
//   the receiver must take it then, as it cannot hold results off.
//   Attribute register: write csr_wdata with csr_valid; csr_ready is always
//   high. Write it only while the block is idle.
// Sequence:
//   A read or a put without scroll strobes its result in the cycle in which
//   busy falls; the block takes no new item before then.
//   A scrolling put first copies the rows up and then clears the freed row,
//   through the single write port of the screen store moving one cell a
//   cycle.
// Reset:
//   Synchronous, active high. Afterwards busy stays high while the whole
//   store is swept to zero.
module text_console_character_writer
   import tccw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_payload,
   output logic              rsp_valid,
   output rsp_type           rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [ATTR_W-1:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // accept attribute writes at any time; the user keeps them to idle periods
   assign csr_ready = 1'b1;

   // sequence each item: load, execute, copy and clear on scroll, respond
   tccw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // hold cursor, attribute and screen store; drive the result item
   tccw_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_wr      (csr_valid && csr_ready),
      .csr_wdata   (csr_wdata)
   );

endmodule

[src/tccw_checker.sv]
// Port-level checker for the text console character writer and its bind.
module tccw_checker
   import tccw_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input req_type           req_payload,
   input logic              rsp_valid,
   input rsp_type           rsp_payload,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic [ATTR_W-1:0] csr_wdata
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted item");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_idle_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.cursor_pos < CURSOR_W'(SCROLL_BASE)))
      else $error("cursor beyond the scroll row");

   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.scrolled) |->
         (rsp_payload.cursor_pos == CURSOR_W'(LAST_ROW_BASE)))
      else $error("scroll left the cursor off the start of the last row");

endmodule

bind text_console_character_writer tccw_checker u_tccw_checker (.*);

[sim/text_console_character_writer_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the text console character writer: directed table, then random items.
module text_console_character_writer_tb;
   import tccw_pkg::*;

   localparam int DIRECTED_ROWS = 22;
   localparam int PHASE_ITEMS   = 610;
   localparam int ITEM_BUDGET   = DIRECTED_ROWS + 3 * PHASE_ITEMS;
   localparam int MAX_GAP       = 40;
   localparam int PRINT_LIMIT   = 60;
   // Worst case per item: longest sender gap plus a full scroll (copy and clear),
   // plus the clearing sweep after reset, all taken twice over.
   localparam int CYCLE_LIMIT   =
      2 * (CELL_COUNT + ITEM_BUDGET * (MAX_GAP + COPY_COUNT + 2 * COLUMNS + 8));

   typedef struct {
      req_type item;
      bit      typed;   // expected result written into the row
      rsp_type want;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_payload;
   logic              rsp_valid;
   rsp_type           rsp_payload;
   logic              csr_valid;
   logic              csr_ready;
   logic [ATTR_W-1:0] csr_wdata;

   // Shadow copy of the screen, cursor and attribute register
   logic [DATA_W-1:0]   screen_shadow [CELL_COUNT];
   logic [CURSOR_W-1:0] cursor_shadow;
   logic [ATTR_W-1:0]   attr_shadow;

   rsp_type      expected_cells [$];
   rsp_type      oldest_cell;
   stim_row_type directed_rows [DIRECTED_ROWS];
   int           error_count = 0;
   int           cycle_count = 0;

   text_console_character_writer dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic report_mismatch(string what, int got, int want);
      if (error_count < PRINT_LIMIT)
         $display("cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got, want);
      error_count++;
   endtask

   // Apply one item to the shadow screen and return the result it produces.
   function automatic rsp_type console_step(req_type item);
      int      pos;
      rsp_type res;
      res = '0;
      pos = cursor_shadow;
      // Cursor can never sit on the last row, but fold it back to cell zero if it ever does
      if (pos >= SCROLL_BASE)
         pos = 0;
      if (item.command == CMD_READ) begin
         // Reads past the store return zero and touch nothing
         if (item.cell_index < CELL_COUNT)
            res.read_data = screen_shadow[item.cell_index];
      end else begin
         if (item.char_code == CODE_NEWLINE) begin
            pos += COLUMNS - pos % COLUMNS;
         end else if (item.char_code == CODE_BACKSPACE) begin
            // Backspace at the very first cell leaves the cursor where it is
            if (pos > 0)
               pos--;
         end else begin
            // Codes above a byte keep only their low byte
            screen_shadow[pos] = {attr_shadow, item.char_code[7:0]};
            pos++;
         end
         if (pos / COLUMNS >= SCROLL_ROW) begin
            // Shift rows up one; the bottom row beyond the scroll area is left alone
            for (int i = 0; i < COPY_COUNT; i++)
               screen_shadow[i] = screen_shadow[i + COLUMNS];
            pos -= COLUMNS;
            for (int i = pos; i < SCROLL_BASE; i++)
               screen_shadow[i] = '0;
            res.scrolled = 1'b1;
         end
         screen_shadow[pos] = {attr_shadow, BLANK_CHAR};
         cursor_shadow = pos[CURSOR_W-1:0];
      end
      res.cursor_pos = cursor_shadow;
      return res;
   endfunction

   // Build one random item: mostly printable text with some line breaks and
   // backspaces, reads biased towards the cells at and just before the cursor.
   function automatic req_type random_item();
      req_type item;
      int      pick;
      int      near;
      item.command = ($urandom_range(99) < 30) ? CMD_READ : CMD_PUT;
      pick = $urandom_range(99);
      if (pick < 66)
         item.char_code = CHAR_W'($urandom_range(8'h7e, 8'h20));
      else if (pick < 74)
         item.char_code = CODE_NEWLINE;
      else if (pick < 80)
         item.char_code = CODE_BACKSPACE;
      else
         item.char_code = CHAR_W'($urandom_range(511));
      pick = $urandom_range(15);
      if (pick == 0) begin
         // Beyond the store, up to all ones
         item.cell_index = INDEX_W'($urandom_range(2047, CELL_COUNT));
      end else if (pick < 8) begin
         near = int'(cursor_shadow) - int'($urandom_range(2 * COLUMNS));
         item.cell_index = INDEX_W'((near < 0) ? 0 : near);
      end else begin
         item.cell_index = INDEX_W'($urandom_range(CELL_COUNT - 1));
      end
      return item;
   endfunction

   // Offer one item, optionally after an idle gap, and log its expected result
   // at the edge that takes it.
   task automatic send_item(req_type item, int idle_pct, bit typed, rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
         gap++;
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start       = 1'b1;
      req_payload = item;
      do @(posedge clock); while (busy);
      predicted = console_step(item);
      expected_cells.push_back(typed ? want : predicted);
   endtask

   // Hold until the block is idle and nothing is outstanding; call at a falling edge.
   task automatic wait_idle();
      while (expected_cells.size() != 0 || busy)
         @(negedge clock);
   endtask

   task automatic write_attribute(logic [ATTR_W-1:0] value);
      wait_idle();
      csr_valid = 1'b1;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      attr_shadow = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic run_random(int count, int idle_pct);
      for (int n = 0; n < count; n++)
         send_item(random_item(), idle_pct, 1'b0, '0);
      // Drop start so the last item is not taken a second time
      @(negedge clock);
      start = 1'b0;
   endtask

   // Result checker: every strobe must match the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_cells.size() == 0) begin
            report_mismatch("result with no item pending, cursor_pos",
                            rsp_payload.cursor_pos, -1);
         end else begin
            oldest_cell = expected_cells.pop_front();
            if (rsp_payload.cursor_pos !== oldest_cell.cursor_pos)
               report_mismatch("cursor_pos", rsp_payload.cursor_pos, oldest_cell.cursor_pos);
            if (rsp_payload.read_data !== oldest_cell.read_data)
               report_mismatch("read_data", rsp_payload.read_data, oldest_cell.read_data);
            if (rsp_payload.scrolled !== oldest_cell.scrolled)
               report_mismatch("scrolled", rsp_payload.scrolled, oldest_cell.scrolled);
         end
      end
   end

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_wdata   = '0;
      for (int i = 0; i < CELL_COUNT; i++)
         screen_shadow[i] = '0;
      cursor_shadow = '0;
      attr_shadow   = ATTR_RESET;

      // Directed items, reset attribute. Rows marked 1 carry their result;
      // the rest go through the shadow model.
      directed_rows = '{
         // Fresh screen: first cell, last cell, all-ones index past the store
         '{'{CMD_READ, 9'd0,          11'd0},     1'b1, '{11'd0, 16'h0000, 1'b0}},
         '{'{CMD_READ, 9'h1ff,        11'd1999},  1'b1, '{11'd0, 16'h0000, 1'b0}},
         '{'{CMD_READ, 9'd0,          11'h7ff},   1'b1, '{11'd0, 16'h0000, 1'b0}},
         // Backspace at cell zero still blanks the cursor cell
         '{'{CMD_PUT,  CODE_BACKSPACE, 11'h7ff},  1'b1, '{11'd0, 16'h0000, 1'b0}},
         '{'{CMD_READ, 9'd0,          11'd0},     1'b1, '{11'd0, 16'h0720, 1'b0}},
         '{'{CMD_PUT,  9'h041,        11'd0},     1'b1, '{11'd1, 16'h0000, 1'b0}},
         '{'{CMD_READ, 9'd0,          11'd0},     1'b1, '{11'd1, 16'h0741, 1'b0}},
         // Code above a byte: only the low byte lands
         '{'{CMD_PUT,  9'h1ff,        11'h555},   1'b1, '{11'd2, 16'h0000, 1'b0}},
         '{'{CMD_READ, 9'd0,          11'd1},     1'b1, '{11'd2, 16'h07ff, 1'b0}},
         '{'{CMD_PUT,  9'h000,        11'h2aa},   1'b1, '{11'd3, 16'h0000, 1'b0}},
         // Nine-bit code whose low byte is a newline is written, not obeyed
         '{'{CMD_PUT,  9'h10a,        11'd0},     1'b1, '{11'd4, 16'h0000, 1'b0}},
         '{'{CMD_READ, 9'd0,          11'd3},     1'b1, '{11'd4, 16'h070a, 1'b0}},
         '{'{CMD_PUT,  CODE_BACKSPACE, 11'd0},    1'b1, '{11'd3, 16'h0000, 1'b0}},
         '{'{CMD_READ, 9'd0,          11'd3},     1'b1, '{11'd3, 16'h0720, 1'b0}},
         '{'{CMD_READ, 9'd0,          11'd4},     1'b0, '0},
         '{'{CMD_PUT,  CODE_NEWLINE,  11'h7ff},   1'b1, '{11'd80, 16'h0000, 1'b0}},
         '{'{CMD_PUT,  9'h0ff,        11'd0},     1'b0, '0},
         '{'{CMD_READ, 9'd0,          11'd2000},  1'b0, '0},
         '{'{CMD_READ, 9'h1ff,        11'd1024},  1'b0, '0},
         '{'{CMD_READ, 9'd0,          11'd80},    1'b0, '0},
         '{'{CMD_PUT,  9'h0fe,        11'h555},   1'b0, '0},
         '{'{CMD_READ, 9'd0,          11'd81},    1'b0, '0}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Hold off through the clearing sweep before the first item
      wait_idle();
      for (int r = 0; r < DIRECTED_ROWS; r++)
         send_item(directed_rows[r].item, 0, directed_rows[r].typed, directed_rows[r].want);
      @(negedge clock);
      start = 1'b0;

      // Lowest attribute, sender seldom idle
      write_attribute(8'h00);
      run_random(PHASE_ITEMS, 8);

      // Highest attribute, sender mostly idle
      write_attribute(8'hff);
      run_random(PHASE_ITEMS, 78);

      // Random attribute, items back to back
      write_attribute(ATTR_W'($urandom_range(255)));
      run_random(PHASE_ITEMS, 0);

      // Drain outstanding results, then keep watching for stray strobes before the verdict
      wait_idle();
      repeat (8) @(negedge clock);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
